>>> sv/md5_pkg.sv
package md5_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_ZFILL,
    ST_LEN,
    ST_OUT
  } state_t;

  // Where the sequencer goes once a compression has been folded in
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_ZFILL,
    RET_OUT
  } ret_t;

  // Four 32-bit working words a, b, c, d
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } words_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [60:0] COUNT_MAX  = {61{1'b1}};
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [5:0]  LAST_FILL  = 6'd63;
  localparam logic [4:0]  LEN_WORD   = 5'd14;
  localparam logic [4:0]  EXTRA_WORD = 5'd15;
  localparam logic [4:0]  BLOCK_END  = 5'd16;
  localparam logic [3:0]  LAST_OUT   = 4'd15;

  // Additive constant of each round
  function automatic logic [31:0] add_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotate amount of each round
  function automatic logic [4:0] shift_amt(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by each round, all arithmetic mod 16
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = {r[1:0], 2'b00} + r[3:0] + 4'd1;
      2'd2: g = {r[2:0], 1'b0} + r[3:0] + 4'd5;
      2'd3: g = {r[0], 3'b000} - r[3:0];
      default: g = r[3:0];
    endcase
    return g;
  endfunction

endpackage

>>> sv/md5_round.sv
module md5_round (
  input  md5_pkg::words_t   words,
  input  logic [31:0]       msg_word,
  input  logic [5:0]        round_index,
  output logic [31:0]       new_b
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;

  // Pick the boolean function of the current quarter
  always_comb begin
    unique case (round_index[5:4])
      2'd0: f = (words.b & words.c) | (~words.b & words.d);
      2'd1: f = (words.d & words.b) | (~words.d & words.c);
      2'd2: f = words.b ^ words.c ^ words.d;
      2'd3: f = words.c ^ (words.b | ~words.d);
      default: f = 32'h0;
    endcase
  end

  // Sum, rotate and add b
  always_comb begin
    sum      = f + words.a + md5_pkg::add_const(round_index) + msg_word;
    rot_wide = {sum, sum} << md5_pkg::shift_amt(round_index);
    new_b    = words.b + rot_wide[63:32];
  end

endmodule

>>> sv/md5_message_digest_core.sv
// MD5 digest engine, one message byte per item.
// Input: pulse start with data_byte, byte_valid and last while busy is low;
// the item is taken at that edge. byte_valid marks a message byte; last ends
// the message (a last item without a byte finishes the message taken so far).
// An item with neither flag is dropped.
// Output: after the last item, sixteen digest bytes come out on consecutive
// cycles, each marked by digest_valid for one cycle, digest_last on the
// sixteenth. The receiver cannot stall; bytes are gone after their cycle.
// Sequence: a byte that does not complete a 64-byte block is stored in the buffer.
// A byte that completes a block starts a compression: 64 rounds through the single
// shared round unit, then a fold of the result into the chaining words. No new
// byte is taken meanwhile, so that round unit sets the rate on long messages.
// Finishing takes a pad step, a zero-fill run, a length step and a compression,
// then the digest output. When the length needs a second block, the first block
// is zero-filled to its end and compressed; the second block is then zero-filled
// up to the length words. busy stays high all through.
// Reset: synchronous; loads the initial vector, clears counts and returns to
// idle. The message buffer is not cleared; each word is written before use.
module md5_message_digest_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       last,
  output logic       digest_valid,
  output logic [7:0] digest_byte,
  output logic       digest_last
);

  md5_pkg::state_t state;
  md5_pkg::state_t state_next;
  md5_pkg::ret_t   ret;
  md5_pkg::words_t chain;
  md5_pkg::words_t round_words;

  logic [31:0] message_words [16];

  logic [5:0]  round_index;
  logic [60:0] byte_count;
  logic [5:0]  fill_position;
  logic [4:0]  zptr;
  logic        len_block;
  logic [3:0]  out_idx;

  logic        accept;
  logic        start_compress;
  logic [4:0]  pad_word;
  logic [31:0] msg_word;
  logic [31:0] new_b;
  logic [31:0] out_word;
  logic [63:0] bit_len;

  assign accept   = start && !busy;
  assign pad_word = {1'b0, fill_position[5:2]} + 5'd1;
  assign msg_word = message_words[md5_pkg::msg_index(round_index)];
  assign bit_len  = {byte_count, 3'b000};

  // Shared round unit
  md5_round u_round (
    .words       (round_words),
    .msg_word    (msg_word),
    .round_index (round_index),
    .new_b       (new_b)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (accept) begin
          if (byte_valid && fill_position == md5_pkg::LAST_FILL) begin
            state_next = md5_pkg::ST_ROUND;
          end else if (last) begin
            state_next = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_ROUND: begin
        if (round_index == md5_pkg::LAST_ROUND) begin
          state_next = md5_pkg::ST_FINAL;
        end
      end
      md5_pkg::ST_FINAL: begin
        unique case (ret)
          md5_pkg::RET_IDLE:  state_next = md5_pkg::ST_IDLE;
          md5_pkg::RET_PAD:   state_next = md5_pkg::ST_PAD;
          md5_pkg::RET_ZFILL: state_next = md5_pkg::ST_ZFILL;
          md5_pkg::RET_OUT:   state_next = md5_pkg::ST_OUT;
          default:            state_next = md5_pkg::ST_IDLE;
        endcase
      end
      md5_pkg::ST_PAD: begin
        state_next = md5_pkg::ST_ZFILL;
      end
      md5_pkg::ST_ZFILL: begin
        if (len_block) begin
          if (zptr >= md5_pkg::LEN_WORD) begin
            state_next = md5_pkg::ST_LEN;
          end
        end else if (zptr == md5_pkg::BLOCK_END) begin
          state_next = md5_pkg::ST_ROUND;
        end
      end
      md5_pkg::ST_LEN: begin
        state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_OUT: begin
        if (out_idx == md5_pkg::LAST_OUT) begin
          state_next = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  // Outputs and strobes
  always_comb begin
    busy           = (state != md5_pkg::ST_IDLE);
    start_compress = (state_next == md5_pkg::ST_ROUND) && (state != md5_pkg::ST_ROUND);
    digest_valid   = (state == md5_pkg::ST_OUT);
    digest_last    = (state == md5_pkg::ST_OUT) && (out_idx == md5_pkg::LAST_OUT);
    unique case (out_idx[3:2])
      2'd0: out_word = chain.a;
      2'd1: out_word = chain.b;
      2'd2: out_word = chain.c;
      2'd3: out_word = chain.d;
      default: out_word = chain.a;
    endcase
    digest_byte = out_word[{out_idx[1:0], 3'b000} +: 8];
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= md5_pkg::ST_IDLE;
      ret           <= md5_pkg::RET_IDLE;
      chain         <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
      round_words   <= '0;
      round_index   <= '0;
      byte_count    <= '0;
      fill_position <= '0;
      zptr          <= '0;
      len_block     <= 1'b0;
      out_idx       <= '0;
    end else begin
      state <= state_next;

      // Load working words at the start of a compression
      if (start_compress) begin
        round_words <= chain;
        round_index <= '0;
      end

      unique case (state)
        md5_pkg::ST_IDLE: begin
          if (accept) begin
            ret <= last ? md5_pkg::RET_PAD : md5_pkg::RET_IDLE;
            if (byte_valid) begin
              fill_position <= fill_position + 6'd1;
              if (byte_count != md5_pkg::COUNT_MAX) begin
                byte_count <= byte_count + 61'd1;
              end
            end
          end
        end
        md5_pkg::ST_ROUND: begin
          round_words <= '{round_words.d, new_b, round_words.b, round_words.c};
          round_index <= round_index + 6'd1;
        end
        md5_pkg::ST_FINAL: begin
          chain.a <= chain.a + round_words.a;
          chain.b <= chain.b + round_words.b;
          chain.c <= chain.c + round_words.c;
          chain.d <= chain.d + round_words.d;
        end
        md5_pkg::ST_PAD: begin
          // Rest of the word is already zero; move to the next word
          zptr          <= pad_word;
          len_block     <= (pad_word < md5_pkg::EXTRA_WORD);
          fill_position <= '0;
          ret           <= md5_pkg::RET_ZFILL;
        end
        md5_pkg::ST_ZFILL: begin
          if (len_block) begin
            if (zptr < md5_pkg::LEN_WORD) begin
              zptr <= zptr + 5'd1;
            end
          end else if (zptr == md5_pkg::BLOCK_END) begin
            // Length goes into a second block
            zptr      <= '0;
            len_block <= 1'b1;
          end else begin
            zptr <= zptr + 5'd1;
          end
        end
        md5_pkg::ST_LEN: begin
          ret <= md5_pkg::RET_OUT;
        end
        md5_pkg::ST_OUT: begin
          out_idx <= out_idx + 4'd1;
          if (out_idx == md5_pkg::LAST_OUT) begin
            chain         <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
            byte_count    <= '0;
            fill_position <= '0;
            ret           <= md5_pkg::RET_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Message buffer writes
  always_ff @(posedge clk) begin
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (accept && byte_valid) begin
          if (fill_position[1:0] == 2'd0) begin
            message_words[fill_position[5:2]] <= {24'h0, data_byte};
          end else begin
            message_words[fill_position[5:2]][{fill_position[1:0], 3'b000} +: 8] <= data_byte;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (fill_position[1:0] == 2'd0) begin
          message_words[fill_position[5:2]] <= {24'h0, md5_pkg::PAD_BYTE};
        end else begin
          message_words[fill_position[5:2]][{fill_position[1:0], 3'b000} +: 8] <=
            md5_pkg::PAD_BYTE;
        end
      end
      md5_pkg::ST_ZFILL: begin
        if ((len_block && zptr < md5_pkg::LEN_WORD) ||
            (!len_block && zptr != md5_pkg::BLOCK_END)) begin
          message_words[zptr[3:0]] <= 32'h0;
        end
      end
      md5_pkg::ST_LEN: begin
        message_words[md5_pkg::LEN_WORD[3:0]]   <= bit_len[31:0];
        message_words[md5_pkg::EXTRA_WORD[3:0]] <= bit_len[63:32];
      end
      default: ;
    endcase
  end

  // Checks
  a_idle_entry: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(state) == md5_pkg::ST_OUT || $past(state) == md5_pkg::ST_FINAL))
    else $error("busy dropped outside digest output or compression end");

  a_round_rest: assert property (@(posedge clk) disable iff (rst)
    state != md5_pkg::ST_ROUND |-> round_index == 6'd0)
    else $error("round counter not at zero outside a compression");

  a_load: assert property (@(posedge clk) disable iff (rst)
    start_compress |=> (state == md5_pkg::ST_ROUND && round_index == 6'd0 &&
                        round_words == $past(chain)))
    else $error("compression did not start from the chaining words");

  a_done: assert property (@(posedge clk) disable iff (rst)
    digest_last |=> (!busy && !digest_valid && chain.a == md5_pkg::IV_A))
    else $error("block not back to idle after digest");

endmodule

>>> tb/md5_digest_checker.sv
module md5_digest_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       last,
  input  logic       digest_valid,
  input  logic [7:0] digest_byte,
  input  logic       digest_last,
  output int         mismatches,
  output int         pending,
  output int         digest_bytes_seen,
  output int         messages_hashed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] value;
    logic       fin;
  } digest_out_t;

  // Per-round additive constants and rotate amounts of RFC 1321
  logic [31:0] sine_k [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  int unsigned rot_by [0:15] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Shadow hash state
  logic [7:0]      block_bytes [0:63];
  int              fill;
  logic [60:0]     msg_len;
  md5_pkg::words_t chain;

  // Digest bytes still owed by the block, oldest first
  digest_out_t digest_bytes_due [$];

  // Run the 64 rounds over the buffered block and fold into the chain
  task compress_block();
    logic [31:0]     m [0:15];
    md5_pkg::words_t w;
    logic [31:0]     f, t, nb;
    int              g, s;
    for (int i = 0; i < 16; i++)
      m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    w = chain;
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (w.b & w.c) | (~w.b & w.d);
          g = r;
        end
        1: begin
          f = (w.d & w.b) | (~w.d & w.c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = w.b ^ w.c ^ w.d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = w.c ^ (w.b | ~w.d);
          g = (7 * r) % 16;
        end
      endcase
      t = f + w.a + sine_k[r] + m[g];
      s = rot_by[(r / 16) * 4 + r % 4];
      nb = w.b + ((t << s) | (t >> (32 - s)));
      w.a = w.d;
      w.d = w.c;
      w.c = w.b;
      w.b = nb;
    end
    chain.a = chain.a + w.a;
    chain.b = chain.b + w.b;
    chain.c = chain.c + w.c;
    chain.d = chain.d + w.d;
  endtask

  // Append one byte to the block; compress when it fills
  task absorb_byte(input logic [7:0] b);
    block_bytes[fill] = b;
    fill++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  task restart_message();
    chain = '{a: md5_pkg::IV_A, b: md5_pkg::IV_B, c: md5_pkg::IV_C, d: md5_pkg::IV_D};
    msg_len = '0;
    fill = 0;
  endtask

  // Advance the shadow state by one accepted item; queue the digest on last
  task take_item(input logic [7:0] b, input logic v, input logic l);
    logic [63:0] bit_len;
    logic [31:0] word;
    digest_out_t d;
    if (v) begin
      absorb_byte(b);
      if (msg_len != '1)
        msg_len = msg_len + 61'd1;
    end
    if (l) begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(8'h80);
      // length no longer fits: pad out this block and start another
      if (fill > 56)
        while (fill != 0) absorb_byte(8'h00);
      while (fill < 56) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++)
        absorb_byte(bit_len[8*k +: 8]);
      for (int i = 0; i < 16; i++) begin
        case (i / 4)
          0: word = chain.a;
          1: word = chain.b;
          2: word = chain.c;
          default: word = chain.d;
        endcase
        d.value = word[8*(i%4) +: 8];
        d.fin = (i == 15);
        digest_bytes_due.push_back(d);
      end
      messages_hashed++;
      restart_message();
    end
  endtask

  task report_mismatch(input string what, input logic [7:0] ev, input logic ef);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, what, ev, ef, digest_byte, digest_last);
  endtask

  // Predict on accepted items, compare each digest byte as it leaves
  always @(posedge clk) begin
    digest_out_t exp_out;
    if (rst) begin
      restart_message();
      digest_bytes_due.delete();
    end else begin
      if (digest_valid) begin
        digest_bytes_seen++;
        if (digest_bytes_due.size() == 0) begin
          report_mismatch("unexpected digest byte", 8'h00, 1'b0);
        end else begin
          exp_out = digest_bytes_due.pop_front();
          if (digest_byte !== exp_out.value || digest_last !== exp_out.fin)
            report_mismatch("digest byte mismatch", exp_out.value, exp_out.fin);
        end
      end
      if (start && !busy)
        take_item(data_byte, byte_valid, last);
    end
    pending = digest_bytes_due.size();
  end

endmodule

>>> tb/md5_message_digest_core_test.sv
module md5_message_digest_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 134;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] data_byte = 8'h00;
  logic       byte_valid = 1'b0;
  logic       last = 1'b0;
  logic       digest_valid;
  logic [7:0] digest_byte;
  logic       digest_last;

  int mismatches, pending, digest_bytes_seen, messages_hashed;
  int idle_pct = 15;
  int msg_items = 0;
  int ignored_items = 0;
  int stall_cycles = 0;

  int boundary_lens [0:9] = '{55, 56, 57, 59, 60, 61, 63, 64, 65, 120};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  md5_message_digest_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .data_byte(data_byte), .byte_valid(byte_valid), .last(last),
    .digest_valid(digest_valid), .digest_byte(digest_byte), .digest_last(digest_last)
  );

  md5_digest_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .data_byte(data_byte), .byte_valid(byte_valid), .last(last),
    .digest_valid(digest_valid), .digest_byte(digest_byte), .digest_last(digest_last),
    .mismatches(mismatches), .pending(pending),
    .digest_bytes_seen(digest_bytes_seen), .messages_hashed(messages_hashed)
  );

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || digest_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[md5_message_digest_core] ERROR");
        $finish;
      end
    end
  end

  // Offer one item, idling at random first; hold it until taken
  task send_item(input logic [7:0] b, input logic v, input logic l);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    data_byte <= b;
    byte_valid <= v;
    last <= l;
    do @(posedge clk); while (busy);
    if (v || l)
      msg_items++;
    else
      ignored_items++;
  endtask

  // Mostly short messages, many at the padding boundaries, a few long ones
  task send_message();
    int sel, len;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      len = $urandom_range(0, 20);
    else if (sel < 85)
      len = boundary_lens[$urandom_range(0, 9)];
    else
      len = $urandom_range(0, 140);
    sel = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      case ($urandom_range(0, 9))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(b, 1'b1, (i == len - 1) && sel == 1);
    end
    // end with a bare last unless the final byte carried it
    if (len == 0 || sel == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty messages, ignored items, byte with last, extremes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);

    // Random messages: light idling, heavy idling, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 15;
        1: idle_pct = 81;
        default: idle_pct = 0;
      endcase
      while (msg_items < 12 + (phase + 1) * PHASE_ITEMS)
        send_message();
    end
    start <= 1'b0;

    // Drain outstanding digests, then let the block settle
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d message items and %0d ignored items; %0d messages hashed,",
             msg_items, ignored_items, messages_hashed);
    $display("%0d digest bytes checked, %0d mismatches.", digest_bytes_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[md5_message_digest_core] OK");
    end else begin
      $display("[md5_message_digest_core] ERROR");
    end
    $finish;
  end

endmodule
